// File: rtl/core/brtu_pkg.sv
// ----------------------------------------------------------------------------
// brtu_pkg: shared types and constants
// Word store geometry, command codes and configuration register codes for the
// backup register file with tamper detection.
// ----------------------------------------------------------------------------
`default_nettype none

package brtu_pkg;

    localparam int NUM_WORDS = 42;
    localparam int DATA_W    = 16;
    localparam int IDX_W     = 6;
    localparam int ADDR_W    = $clog2(NUM_WORDS);
    localparam int CAL_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = CAL_W;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_TAMPER = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAMPER_EN  = 3'd0,
        CFG_ACTIVE_LOW = 3'd1,
        CFG_IRQ_EN     = 3'd2,
        CFG_RTC_CAL    = 3'd3,
        CFG_PULSE_EN   = 3'd4,
        CFG_PULSE_SEL  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic             tamper_en;
        logic             active_low;
        logic             irq_en;
        logic [CAL_W-1:0] rtc_cal;
        logic             pulse_en;
        logic             pulse_sel;
    } t_cfg;

    typedef logic [DATA_W-1:0] t_word;

endpackage

`default_nettype wire

// File: rtl/core/brtu_if.sv
// ----------------------------------------------------------------------------
// brtu channels: command and result interfaces
// Valid/ready channels carrying one command item or one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface brtu_in_if
    import brtu_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       cmd;
    logic [IDX_W-1:0] reg_index;
    t_word            write_data;
    logic             tamper_pin;
    logic             clear_event;
    logic             clear_interrupt;

    modport source (
        output valid, cmd, reg_index, write_data, tamper_pin, clear_event,
               clear_interrupt,
        input  ready
    );
    modport sink (
        input  valid, cmd, reg_index, write_data, tamper_pin, clear_event,
               clear_interrupt,
        output ready
    );
endinterface

interface brtu_out_if
    import brtu_pkg::*;
();
    logic  valid;
    logic  ready;
    t_word read_data;
    logic  access_valid;
    logic  event_flag;
    logic  interrupt_flag;
    logic  irq_request;

    modport source (
        output valid, read_data, access_valid, event_flag, interrupt_flag,
               irq_request,
        input  ready
    );
    modport sink (
        input  valid, read_data, access_valid, event_flag, interrupt_flag,
               irq_request,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/backup_regs_tamper_unit.sv
// ----------------------------------------------------------------------------
// backup_regs_tamper_unit: backup word store with tamper detection
// Channel    | dir | transfer when      | payload
// i_in_ch    | in  | valid && ready     | cmd, reg_index, write_data, pin, clears
// o_out_ch   | out | valid && ready     | read_data, access_valid, flags, irq
// i_cfg_*    | in  | i_cfg_we           | register index, data
//
// One item per cycle while the result channel is not stalled.
// The word store is read and written at the input transfer edge, its read
// data lands in a stage register, then in the output register.
// Per-word valid bits are cleared by reset and by a tamper edge, so the
// store needs no clearing pass; an invalid word reads as zero.
// Input is taken while the stage register is empty or moving on, so a
// stalled result holds one more item behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module backup_regs_tamper_unit
    import brtu_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_wdata,
    brtu_in_if.sink                   i_in_ch,
    brtu_out_if.source                o_out_ch
);

    t_cfg r_cfg;

    t_word r_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_word_vld, n_word_vld;

    logic r_event, n_event;
    logic r_intr, n_intr;
    logic r_pin_was, n_pin_was;

    // stage register
    logic  r_s1_v;
    t_word r_s1_word;
    logic  r_s1_hit;
    logic  r_s1_acc;
    logic  r_s1_event;
    logic  r_s1_intr;
    logic  r_s1_irq;

    // output register
    logic  r_o_v;
    t_word r_o_data;
    logic  r_o_acc;
    logic  r_o_event;
    logic  r_o_intr;
    logic  r_o_irq;

    logic              in_xfer;
    logic              s1_move;
    logic              idx_ok;
    logic [ADDR_W-1:0] addr;
    logic              active;
    logic              tamper_edge;
    logic              wr_en;
    logic              rd_hit;
    t_cmd              cmd;

    assign cmd     = t_cmd'(i_in_ch.cmd);
    assign s1_move = r_s1_v && (!r_o_v || o_out_ch.ready);
    assign i_in_ch.ready = !r_s1_v || s1_move;
    assign in_xfer = i_in_ch.valid && i_in_ch.ready;

    assign idx_ok = (i_in_ch.reg_index != '0)
                 && (i_in_ch.reg_index <= IDX_W'(NUM_WORDS));
    assign addr   = ADDR_W'(i_in_ch.reg_index - IDX_W'(1));
    assign active = i_in_ch.tamper_pin ^ r_cfg.active_low;
    assign tamper_edge = (cmd == CMD_TAMPER) && r_cfg.tamper_en && active && !r_pin_was;
    assign wr_en  = (cmd == CMD_WRITE) && idx_ok;
    assign rd_hit = (cmd == CMD_READ) && idx_ok && r_word_vld[addr];

    always_comb begin
        n_event    = r_event;
        n_intr     = r_intr;
        n_pin_was  = r_pin_was;
        n_word_vld = r_word_vld;
        unique case (cmd)
            CMD_WRITE: begin
                if (idx_ok) begin
                    n_word_vld[addr] = 1'b1;
                end
            end
            CMD_READ: begin
            end
            CMD_TAMPER: begin
                n_pin_was = active;
                if (tamper_edge) begin
                    n_event    = 1'b1;
                    n_word_vld = '0;
                    if (r_cfg.irq_en) begin
                        n_intr = 1'b1;
                    end
                end
            end
            CMD_CLEAR: begin
                if (i_in_ch.clear_event) begin
                    n_event = 1'b0;
                end
                if (i_in_ch.clear_interrupt) begin
                    n_intr = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TAMPER_EN:  r_cfg.tamper_en  <= i_cfg_wdata[0];
                CFG_ACTIVE_LOW: r_cfg.active_low <= i_cfg_wdata[0];
                CFG_IRQ_EN:     r_cfg.irq_en     <= i_cfg_wdata[0];
                CFG_RTC_CAL:    r_cfg.rtc_cal    <= i_cfg_wdata[CAL_W-1:0];
                CFG_PULSE_EN:   r_cfg.pulse_en   <= i_cfg_wdata[0];
                CFG_PULSE_SEL:  r_cfg.pulse_sel  <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // word store: write and registered read at the input transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            if (wr_en) begin
                r_mem[addr] <= i_in_ch.write_data;
            end
            r_s1_word <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event    <= 1'b0;
            r_intr     <= 1'b0;
            r_pin_was  <= 1'b0;
            r_word_vld <= '0;
        end else if (in_xfer) begin
            r_event    <= n_event;
            r_intr     <= n_intr;
            r_pin_was  <= n_pin_was;
            r_word_vld <= n_word_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_xfer) begin
            r_s1_v <= 1'b1;
        end else if (s1_move) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_hit   <= rd_hit;
            r_s1_acc   <= idx_ok && ((cmd == CMD_WRITE) || (cmd == CMD_READ));
            r_s1_event <= n_event;
            r_s1_intr  <= n_intr;
            r_s1_irq   <= n_intr && r_cfg.irq_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (s1_move) begin
            r_o_v <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_data  <= r_s1_hit ? r_s1_word : '0;
            r_o_acc   <= r_s1_acc;
            r_o_event <= r_s1_event;
            r_o_intr  <= r_s1_intr;
            r_o_irq   <= r_s1_irq;
        end
    end

    assign o_out_ch.valid          = r_o_v;
    assign o_out_ch.read_data      = r_o_data;
    assign o_out_ch.access_valid   = r_o_acc;
    assign o_out_ch.event_flag     = r_o_event;
    assign o_out_ch.interrupt_flag = r_o_intr;
    assign o_out_ch.irq_request    = r_o_irq;

endmodule

`default_nettype wire

// File: rtl/core/brtu_checker.sv
// ----------------------------------------------------------------------------
// brtu_checker: port-level checks for the backup word store
// Watches the result channel and reset behavior of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module brtu_checker
    import brtu_pkg::*;
(
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    input wire logic  i_out_valid,
    input wire logic  i_out_ready,
    input wire t_word i_read_data,
    input wire logic  i_access_valid,
    input wire logic  i_interrupt_flag,
    input wire logic  i_irq_request
);

    // a request is only raised from a set interrupt flag
    a_irq_needs_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!i_irq_request || i_interrupt_flag))
        else $error("irq_request without interrupt_flag");

    // nonzero read data only comes from a valid access
    a_data_needs_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_read_data != '0)) |-> i_access_valid)
        else $error("read_data nonzero on invalid access");

    // reset drops the result channel
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_read_data)))
        else $error("stalled result changed");

endmodule

bind backup_regs_tamper_unit brtu_checker u_brtu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out_ch.valid),
    .i_out_ready      (o_out_ch.ready),
    .i_read_data      (o_out_ch.read_data),
    .i_access_valid   (o_out_ch.access_valid),
    .i_interrupt_flag (o_out_ch.interrupt_flag),
    .i_irq_request    (o_out_ch.irq_request)
);

`default_nettype wire

// File: verif/backup_regs_tamper_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backup_regs_tamper_unit_test: self-checking bench for the backup word store
// Drives command transfers through the input channel and compares every
// status transfer against a cycle-free shadow of the word store, the tamper
// flags and the configuration registers. The directed tests cover the index
// limits, tamper edges and flag clearing. The random phases mix source and
// sink idling, and one stretch of sink hold-off fills the pipeline.
// ----------------------------------------------------------------------------

module backup_regs_tamper_unit_test;
    import brtu_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int CHUNK_ITEMS = 54;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(CFG_PULSE_SEL + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(CFG_PULSE_SEL + 2);

    typedef struct {
        t_cmd             cmd;
        logic [IDX_W-1:0] idx;
        t_word            data;
        logic             pin;
        logic             clr_ev;
        logic             clr_it;
    } t_store_cmd;

    typedef struct packed {
        t_word read_data;
        logic  access_valid;
        logic  event_flag;
        logic  interrupt_flag;
        logic  irq_request;
    } t_status;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DAT_W-1:0] cfg_wdata;

    brtu_in_if  cmd_ch ();
    brtu_out_if res_ch ();

    backup_regs_tamper_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_ch     (cmd_ch),
        .o_out_ch    (res_ch)
    );

    // shadow state
    t_word   shadow_words [1:NUM_WORDS];
    logic    shadow_event;
    logic    shadow_interrupt;
    logic    shadow_pin_active;
    t_cfg    shadow_cfg;
    t_status pending_status [$];

    int  src_idle_pct;
    int  sink_idle_pct;
    int  hold_request;
    int  errors;
    int  cmds_sent;
    int  status_checked;
    int  tamper_edges;
    logic pin_level;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the block
    // ------------------------------------------------------------------
    function automatic void shadow_reset();
        for (int i = 1; i <= NUM_WORDS; i++) shadow_words[i] = '0;
        shadow_event      = 1'b0;
        shadow_interrupt  = 1'b0;
        shadow_pin_active = 1'b0;
        shadow_cfg        = '0;
    endfunction

    function automatic void shadow_cfg_write(input logic [CFG_IDX_W-1:0] idx,
                                             input logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_TAMPER_EN:  shadow_cfg.tamper_en  = data[0];
            CFG_ACTIVE_LOW: shadow_cfg.active_low = data[0];
            CFG_IRQ_EN:     shadow_cfg.irq_en     = data[0];
            CFG_RTC_CAL:    shadow_cfg.rtc_cal    = data[CAL_W-1:0];
            CFG_PULSE_EN:   shadow_cfg.pulse_en   = data[0];
            CFG_PULSE_SEL:  shadow_cfg.pulse_sel  = data[0];
            default: ;
        endcase
    endfunction

    function automatic t_status apply_command(input t_store_cmd c);
        t_status s;
        logic    active;
        logic    in_range;
        s        = '0;
        in_range = (c.idx >= 1) && (c.idx <= NUM_WORDS);
        case (c.cmd)
            CMD_WRITE: begin
                if (in_range) begin
                    shadow_words[c.idx] = c.data;
                    s.access_valid = 1'b1;
                end
            end
            CMD_READ: begin
                if (in_range) begin
                    s.read_data    = shadow_words[c.idx];
                    s.access_valid = 1'b1;
                end
            end
            CMD_TAMPER: begin
                active = c.pin ^ shadow_cfg.active_low;
                // only a fresh edge to the active level counts
                if (shadow_cfg.tamper_en && active && !shadow_pin_active) begin
                    shadow_event = 1'b1;
                    if (shadow_cfg.irq_en) shadow_interrupt = 1'b1;
                    for (int i = 1; i <= NUM_WORDS; i++) shadow_words[i] = '0;
                    tamper_edges++;
                end
                shadow_pin_active = active;
            end
            default: begin
                if (c.clr_ev) shadow_event = 1'b0;
                if (c.clr_it) shadow_interrupt = 1'b0;
            end
        endcase
        s.event_flag     = shadow_event;
        s.interrupt_flag = shadow_interrupt;
        s.irq_request    = shadow_interrupt & shadow_cfg.irq_en;
        return s;
    endfunction

    function automatic t_store_cmd make_cmd(input t_cmd cmd, input logic [IDX_W-1:0] idx,
                                            input t_word data, input logic pin,
                                            input logic clr_ev, input logic clr_it);
        t_store_cmd c;
        c.cmd    = cmd;
        c.idx    = idx;
        c.data   = data;
        c.pin    = pin;
        c.clr_ev = clr_ev;
        c.clr_it = clr_it;
        return c;
    endfunction

    function automatic t_store_cmd random_command();
        t_store_cmd  c;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 38)      c.cmd = CMD_WRITE;
        else if (roll < 78) c.cmd = CMD_READ;
        else if (roll < 90) c.cmd = CMD_TAMPER;
        else                c.cmd = CMD_CLEAR;
        if ($urandom_range(9) == 0) c.idx = IDX_W'($urandom);
        else                        c.idx = IDX_W'($urandom_range(NUM_WORDS, 1));
        c.data   = t_word'($urandom);
        c.clr_ev = 1'($urandom);
        c.clr_it = 1'($urandom);
        if (c.cmd == CMD_TAMPER) begin
            // keep the pin level sticky so edges stay occasional
            if ($urandom_range(99) < 40) pin_level = ~pin_level;
            c.pin = pin_level;
        end else begin
            c.pin = 1'($urandom);
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_cmd(input t_store_cmd c);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid           <= 1'b1;
        cmd_ch.cmd             <= c.cmd;
        cmd_ch.reg_index       <= c.idx;
        cmd_ch.write_data      <= c.data;
        cmd_ch.tamper_pin      <= c.pin;
        cmd_ch.clear_event     <= c.clr_ev;
        cmd_ch.clear_interrupt <= c.clr_it;
        do @(posedge clk); while (!cmd_ch.ready);
        // transfer taken at this edge; valid stays up for the next call
        pending_status.push_back(apply_command(c));
        cmds_sent++;
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        shadow_cfg_write(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_config();
        logic [CFG_DAT_W-1:0] cal;
        case ($urandom_range(2))
            0:       cal = '0;
            1:       cal = '1;
            default: cal = CFG_DAT_W'($urandom);
        endcase
        write_reg(CFG_TAMPER_EN,
                  {(CFG_DAT_W-1)'($urandom), 1'($urandom_range(99) < 80)});
        write_reg(CFG_ACTIVE_LOW, CFG_DAT_W'($urandom));
        write_reg(CFG_IRQ_EN, CFG_DAT_W'($urandom));
        write_reg(CFG_RTC_CAL, cal);
        write_reg(CFG_PULSE_EN, CFG_DAT_W'($urandom));
        write_reg(CFG_PULSE_SEL, CFG_DAT_W'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_word_access();
        send_cmd(make_cmd(CMD_WRITE, 6'd1, 16'hffff, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(CMD_WRITE, 6'd42, 16'h0000, 1'b1, 1'b1, 1'b1));
        send_cmd(make_cmd(CMD_WRITE, 6'd0, 16'h1234, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(CMD_WRITE, 6'd43, 16'hbeef, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(CMD_READ, 6'd0, 16'h0000, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(CMD_READ, 6'd1, 16'h0000, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(CMD_READ, 6'd42, 16'hffff, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(CMD_READ, 6'd43, 16'h0000, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(CMD_READ, 6'd63, 16'h0000, 1'b0, 1'b0, 1'b0));
        drain();
    endtask

    task automatic test_tamper_flags();
        write_reg(CFG_TAMPER_EN, 6'd1);
        write_reg(CFG_ACTIVE_LOW, 6'd0);
        write_reg(CFG_IRQ_EN, 6'd1);
        send_cmd(make_cmd(CMD_WRITE, 6'd7, 16'h8001, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(CMD_TAMPER, 6'd7, 16'h0000, 1'b1, 1'b0, 1'b0));
        send_cmd(make_cmd(CMD_READ, 6'd7, 16'h0000, 1'b0, 1'b0, 1'b0));
        // pin held active: no new edge
        send_cmd(make_cmd(CMD_TAMPER, 6'd0, 16'h0000, 1'b1, 1'b0, 1'b0));
        send_cmd(make_cmd(CMD_WRITE, 6'd7, 16'h7ffe, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(CMD_TAMPER, 6'd0, 16'h0000, 1'b0, 1'b0, 1'b0));
        // edge again with both flags still set
        send_cmd(make_cmd(CMD_TAMPER, 6'd0, 16'h0000, 1'b1, 1'b0, 1'b0));
        send_cmd(make_cmd(CMD_READ, 6'd7, 16'h0000, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(CMD_CLEAR, 6'd63, 16'hffff, 1'b0, 1'b1, 1'b0));
        drain();
        // masking the request leaves the interrupt flag alone
        write_reg(CFG_IRQ_EN, 6'd0);
        send_cmd(make_cmd(CMD_CLEAR, 6'd0, 16'h0000, 1'b1, 1'b0, 1'b0));
        send_cmd(make_cmd(CMD_CLEAR, 6'd42, 16'h5a5a, 1'b0, 1'b0, 1'b1));
        send_cmd(make_cmd(CMD_CLEAR, 6'd1, 16'ha5a5, 1'b1, 1'b1, 1'b1));
        drain();
    endtask

    task automatic test_enable_while_active();
        write_reg(CFG_TAMPER_EN, 6'd0);
        write_reg(CFG_ACTIVE_LOW, 6'd1);
        send_cmd(make_cmd(CMD_TAMPER, 6'd0, 16'h0000, 1'b0, 1'b0, 1'b0));
        drain();
        write_reg(CFG_TAMPER_EN, 6'd1);
        send_cmd(make_cmd(CMD_TAMPER, 6'd0, 16'h0000, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(CMD_TAMPER, 6'd0, 16'h0000, 1'b1, 1'b0, 1'b0));
        send_cmd(make_cmd(CMD_TAMPER, 6'd0, 16'h0000, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(CMD_CLEAR, 6'd0, 16'h0000, 1'b0, 1'b1, 1'b1));
        drain();
    endtask

    task automatic test_config_regs();
        write_reg(CFG_RTC_CAL, '1);
        write_reg(CFG_RTC_CAL, '0);
        write_reg(CFG_PULSE_EN, '1);
        write_reg(CFG_PULSE_SEL, '1);
        write_reg(CFG_PULSE_EN, '0);
        write_reg(CFG_PULSE_SEL, '0);
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '1);
    endtask

    task automatic test_random_mix(input int src_pct, input int sink_pct, input int chunks);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int k = 0; k < chunks; k++) begin
            random_config();
            repeat (CHUNK_ITEMS) send_cmd(random_command());
            drain();
        end
    endtask

    task automatic test_output_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_config();
        hold_request  = HOLD_OFF_CYCLES;
        repeat (40) send_cmd(random_command());
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sink side: random ready, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin : sink_ready
        int hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge clk) begin : status_check
        t_status want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_status.size() == 0) begin
                $error("status transfer with nothing pending");
                errors++;
            end else begin
                want = pending_status.pop_front();
                status_checked++;
                if (res_ch.read_data !== want.read_data) begin
                    $error("read_data: expected %h, got %h", want.read_data, res_ch.read_data);
                    errors++;
                end
                if (res_ch.access_valid !== want.access_valid) begin
                    $error("access_valid: expected %b, got %b",
                           want.access_valid, res_ch.access_valid);
                    errors++;
                end
                if (res_ch.event_flag !== want.event_flag) begin
                    $error("event_flag: expected %b, got %b", want.event_flag, res_ch.event_flag);
                    errors++;
                end
                if (res_ch.interrupt_flag !== want.interrupt_flag) begin
                    $error("interrupt_flag: expected %b, got %b",
                           want.interrupt_flag, res_ch.interrupt_flag);
                    errors++;
                end
                if (res_ch.irq_request !== want.irq_request) begin
                    $error("irq_request: expected %b, got %b", want.irq_request, res_ch.irq_request);
                    errors++;
                end
            end
        end
    end

    // count cycles where work is outstanding but nothing moves
    always @(posedge clk) begin : watchdog
        int quiet;
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (!cmd_ch.valid && pending_status.size() == 0)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("backup_regs_tamper_unit test failed");
                $finish;
            end
        end
    end

    initial begin
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_idx                <= '0;
        cfg_wdata              <= '0;
        cmd_ch.valid           <= 1'b0;
        cmd_ch.cmd             <= CMD_WRITE;
        cmd_ch.reg_index       <= '0;
        cmd_ch.write_data      <= '0;
        cmd_ch.tamper_pin      <= 1'b0;
        cmd_ch.clear_event     <= 1'b0;
        cmd_ch.clear_interrupt <= 1'b0;
        src_idle_pct   = 37;
        sink_idle_pct  = 68;
        hold_request   = 0;
        errors         = 0;
        cmds_sent      = 0;
        status_checked = 0;
        tamper_edges   = 0;
        pin_level      = 1'b0;
        shadow_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_word_access();
        test_tamper_flags();
        test_enable_while_active();
        test_config_regs();
        test_random_mix(37, 68, 3);
        test_random_mix(68, 37, 3);
        test_random_mix(0, 0, 3);
        test_output_backpressure();

        $display("Ran %0d commands, compared %0d status transfers, %0d tamper edges fired.",
                 cmds_sent, status_checked, tamper_edges);
        $display("Covered index limits, flag clears, irq masking and a long sink hold-off.");
        if (errors == 0 && pending_status.size() == 0) begin
            $display("backup_regs_tamper_unit test passed");
        end else begin
            $display("backup_regs_tamper_unit test failed");
        end
        $finish;
    end

endmodule
